// ===== src/opcp_pkg.sv =====
// shared types and constants of the ofdm preamble cyclic prefixer
// no dependencies; used by the channel interfaces and the top level
package opcp_pkg;

    localparam int FFT_LEN  = 64;
    localparam int AW       = (FFT_LEN > 1) ? $clog2(FFT_LEN) : 1;
    localparam int CW       = $clog2(FFT_LEN + FFT_LEN / 2 + 1);
    localparam int XW       = CW + 1;
    localparam int PREFIX_W = 6;
    localparam int HALF_FFT = FFT_LEN / 2;

    localparam logic [PREFIX_W-1:0] PREFIX_RESET = PREFIX_W'(16);

    typedef logic signed [15:0] t_iq;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_PULL = 2'd1,
        CMD_REF  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_SAMPLE   = 2'd2,
        ST_NO_DATA  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0] cmd;
        t_iq        sample_re;
        t_iq        sample_im;
        logic [5:0] ref_index;
    } t_req;

endpackage

// ===== src/opcp_in_if.sv =====
// request channel of the ofdm preamble cyclic prefixer
// depends on opcp_pkg
interface opcp_in_if
    import opcp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    t_iq        sample_re;
    t_iq        sample_im;
    logic [5:0] ref_index;

    modport source (output valid, cmd, sample_re, sample_im, ref_index, input ready);
    modport sink   (input valid, cmd, sample_re, sample_im, ref_index, output ready);
endinterface

// ===== src/opcp_out_if.sv =====
// result channel of the ofdm preamble cyclic prefixer
// depends on opcp_pkg
interface opcp_out_if
    import opcp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    t_iq        out_re;
    t_iq        out_im;
    logic       last;

    modport source (output valid, status, out_re, out_im, last, input ready);
    modport sink   (input valid, status, out_re, out_im, last, output ready);
endinterface

// ===== src/opcp_cfg_if.sv =====
// configuration write channel carrying the prefix length
// depends on opcp_pkg
interface opcp_cfg_if
    import opcp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PREFIX_W-1:0] prefix_len;

    modport source (output valid, prefix_len, input ready);
    modport sink   (input valid, prefix_len, output ready);
endinterface

// ===== src/ofdm_preamble_cyclic_prefixer_top.sv =====
// ofdm cyclic prefix inserter with four-phase preamble tracker, top level
// depends on opcp_pkg, opcp_in_if, opcp_out_if and opcp_cfg_if
//
// usage:
//   i_in carries one request: push a symbol sample, pull an output sample or
//   write a short-preamble reference entry. o_out returns one result per
//   request: status, sample and a last flag on the final prefixed sample.
//   i_cfg writes the prefix length; it is always ready. the user must write it
//   only while no request is in flight; the block itself does not enforce it.
// request flow:
//   a request is taken in S_IDLE and executed in S_EXEC, and its result is
//   registered in the output register. i_in is ready only in S_IDLE, so no
//   new request is taken until the last one has left S_EXEC; the symbol or
//   reference memory is read synchronously before the read-modify-write
//   completes.
// reset:
//   i_rst_n clears the tracker to phase 0, empties the symbol buffer and sets
//   the prefix length to 16. memory contents are not cleared; the reference
//   must be loaded before the first symbol.
// stall:
//   a request is still taken while a result waits in the output register;
//   its execution holds until that result is taken.
module ofdm_preamble_cyclic_prefixer_top
    import opcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    opcp_in_if.sink    i_in,
    opcp_out_if.source o_out,
    opcp_cfg_if.sink   i_cfg
);

    logic [31:0] symbol_mem [FFT_LEN];
    logic [31:0] ref_mem    [FFT_LEN];

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [PREFIX_W-1:0] r_prefix;
    logic [1:0]          r_phase, n_phase;
    logic [CW-1:0]       r_load_count, n_load_count;
    logic [CW-1:0]       r_emit_count, n_emit_count;
    logic                r_draining, n_draining;
    logic                r_match, n_match;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    t_iq                 r_out_re, n_out_re;
    t_iq                 r_out_im, n_out_im;
    logic                r_out_last, n_out_last;
    logic [31:0]         r_sym_rd, r_ref_rd;

    logic [CW-1:0] prefix_ext, eff_prefix;
    logic [XW-1:0] lead, emit_ext, raw_idx, wrap_idx, total;
    logic [AW-1:0] sym_rd_addr, ref_rd_addr, ref_wr_addr;
    logic          fin, can_load, sym_we, ref_we;
    logic [31:0]   packed_sample;

    // read addresses and the end-of-symbol flag from the buffer state
    always_comb begin
        prefix_ext = CW'(r_prefix);
        eff_prefix = (prefix_ext > CW'(HALF_FFT)) ? CW'(HALF_FFT) : prefix_ext;
        lead       = (r_phase == 2'd2) ? (XW'(eff_prefix) << 1) : XW'(eff_prefix);
        emit_ext   = XW'(r_emit_count);
        if (emit_ext < lead) begin
            raw_idx = XW'(FFT_LEN) - lead + emit_ext;
        end else begin
            raw_idx = emit_ext - lead;
        end
        wrap_idx    = (raw_idx >= XW'(FFT_LEN)) ? raw_idx - XW'(FFT_LEN) : raw_idx;
        sym_rd_addr = wrap_idx[AW-1:0];
        ref_rd_addr = r_load_count[AW-1:0];
        total       = XW'(FFT_LEN) + XW'(eff_prefix);
        fin         = (emit_ext + XW'(1)) >= total;
    end

    assign packed_sample = {r_req.sample_re, r_req.sample_im};
    assign ref_wr_addr   = AW'(r_req.ref_index);
    assign can_load      = !r_out_valid || o_out.ready;

    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.out_re = r_out_re;
    assign o_out.out_im = r_out_im;
    assign o_out.last   = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_phase      = r_phase;
        n_load_count = r_load_count;
        n_emit_count = r_emit_count;
        n_draining   = r_draining;
        n_match      = r_match;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_re     = r_out_re;
        n_out_im     = r_out_im;
        n_out_last   = r_out_last;
        sym_we       = 1'b0;
        ref_we       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_req.cmd       = i_in.cmd;
                    n_req.sample_re = i_in.sample_re;
                    n_req.sample_im = i_in.sample_im;
                    n_req.ref_index = i_in.ref_index;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_load) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ACCEPTED;
                    n_out_re     = '0;
                    n_out_im     = '0;
                    n_out_last   = 1'b0;
                    unique case (r_req.cmd)
                        CMD_PUSH: begin
                            if (r_draining) begin
                                n_out_status = ST_DROPPED;
                            end else begin
                                sym_we       = 1'b1;
                                if (r_ref_rd != packed_sample) begin
                                    n_match = 1'b0;
                                end
                                n_load_count = r_load_count + CW'(1);
                                if (n_load_count == CW'(FFT_LEN)) begin
                                    n_draining   = 1'b1;
                                    n_emit_count = '0;
                                end
                            end
                        end
                        CMD_PULL: begin
                            if (!r_draining) begin
                                n_out_status = ST_NO_DATA;
                            end else begin
                                n_out_status = ST_SAMPLE;
                                n_out_re     = r_sym_rd[31:16];
                                n_out_im     = r_sym_rd[15:0];
                                n_out_last   = fin;
                                if (fin) begin
                                    if (r_phase == 2'd0) begin
                                        if (r_match) begin
                                            n_phase = 2'd1;
                                        end
                                    end else begin
                                        n_phase = r_phase + 2'd1;
                                    end
                                    n_draining   = 1'b0;
                                    n_load_count = '0;
                                    n_emit_count = '0;
                                    n_match      = 1'b1;
                                end else begin
                                    n_emit_count = r_emit_count + CW'(1);
                                end
                            end
                        end
                        CMD_REF: begin
                            ref_we = (int'(r_req.ref_index) < FFT_LEN);
                        end
                        default: begin
                            n_out_status = ST_ACCEPTED;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prefix     <= PREFIX_RESET;
            r_phase      <= 2'd0;
            r_load_count <= '0;
            r_emit_count <= '0;
            r_draining   <= 1'b0;
            r_match      <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_load_count <= n_load_count;
            r_emit_count <= n_emit_count;
            r_draining   <= n_draining;
            r_match      <= n_match;
            r_out_valid  <= n_out_valid;
            if (i_cfg.valid) begin
                r_prefix <= i_cfg.prefix_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_out_status <= n_out_status;
        r_out_re     <= n_out_re;
        r_out_im     <= n_out_im;
        r_out_last   <= n_out_last;
    end

    // symbol and reference memories, read every cycle at the state address
    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            symbol_mem[ref_rd_addr] <= packed_sample;
        end
        r_sym_rd <= symbol_mem[sym_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            ref_mem[ref_wr_addr] <= packed_sample;
        end
        r_ref_rd <= ref_mem[ref_rd_addr];
    end

    a_drain_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_load_count == CW'(FFT_LEN)))
        else $error("draining with a partial symbol");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_draining |-> (r_emit_count == '0))
        else $error("emit count nonzero while loading");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && can_load) |=> (r_out_valid && r_state == S_IDLE))
        else $error("executed request gave no result");

    a_last_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_status == ST_SAMPLE))
        else $error("last flag on a non-sample result");

    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != $past(r_phase)) |-> ($past(r_draining) && !r_draining))
        else $error("phase moved outside the end of a symbol");

endmodule
